FILE: rtl/sis_pkg.sv
// Shared types and constants for the sorted integer set unit.
// No dependencies; imported by sis_cell and sorted_integer_set_unit.
`default_nettype none

package sis_pkg;

	localparam int CAPACITY  = 64;
	localparam int KEY_W     = 32;
	localparam int IDX_W     = $clog2(CAPACITY);
	localparam int CNT_W     = $clog2(CAPACITY + 1);
	localparam int POS_OUT_W = 6;
	localparam int CNT_OUT_W = 7;
	localparam int REQ_W     = 2;
	localparam int STAT_W    = 2;

	typedef logic signed [KEY_W-1:0] key_t;
	typedef logic [IDX_W-1:0]        idx_t;
	typedef logic [CNT_W-1:0]        cnt_t;

	typedef enum logic [REQ_W-1:0] {
		REQ_LOOKUP = 2'd0,
		REQ_INSERT = 2'd1,
		REQ_DELETE = 2'd2
	} req_t;

	typedef enum logic [STAT_W-1:0] {
		STAT_OK   = 2'd0,
		STAT_MISS = 2'd1,
		STAT_DUP  = 2'd2,
		STAT_FULL = 2'd3
	} status_t;

	// Broadcast to every cell of the chain.
	typedef struct packed {
		logic compare;
		logic insert;
		logic remove;
	} cell_ctl_t;

endpackage

`default_nettype wire

FILE: rtl/sis_cell.sv
// One storage cell of the sorted key chain: holds a key, compares it
// against the request key and shifts with its neighbors. Uses sis_pkg.
`default_nettype none

module sis_cell (
	input  wire                clk,
	input  wire                arst_n,
	input  sis_pkg::cell_ctl_t ctl,
	input  sis_pkg::key_t      cmp_key,
	input  sis_pkg::key_t      ins_key,
	input  wire                occupied,
	input  wire                left_lt,
	input  sis_pkg::key_t      left_key,
	input  sis_pkg::key_t      right_key,
	output sis_pkg::key_t      key_q,
	output logic               lt_q,
	output logic               eq_q
);
	import sis_pkg::*;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lt_q <= 1'b0;
			eq_q <= 1'b0;
		end else if (ctl.compare) begin
			lt_q <= occupied && (key_q < cmp_key);
			eq_q <= occupied && (key_q == cmp_key);
		end
	end

	// At/above the point, insert takes the left key (first cell: new key), delete the right key.
	always_ff @(posedge clk) begin
		if (ctl.insert && !lt_q) begin
			key_q <= left_lt ? ins_key : left_key;
		end else if (ctl.remove && !lt_q) begin
			key_q <= right_key;
		end
	end

endmodule

`default_nettype wire

FILE: rtl/sorted_integer_set_unit.sv
// Top level of the sorted integer set: a chain of sis_cell storage cells,
// request staging and the result register. Uses sis_pkg and sis_cell.
//
// Usage:
//   Slave channel: s_tuser carries the request (0 lookup, 1 insert,
//   2 delete, 3 treated as lookup), s_tdata the signed 32-bit key.
//   Master channel: one result per request in m_tdata: found, position,
//   status (0 ok, 1 not found, 2 already present, 3 full) and the count
//   of keys held after the request.
//   Sequence: a request is compared against every cell at once at the edge
//   that accepts it; its result is registered when it advances, at the edge
//   at which the chain shifts for an insert or delete, and then waits for m_tready.
//   Flow: no new request is taken until the staged one has advanced, as
//   the cell chain alternates a compare step and a shift/commit step;
//   s_tready stays low while a request sits in the compare stage.
//   When m_tready is low the result holds in the output register and the
//   staged request waits; the chain changes only when its result moves
//   into the output register.
//   Reset (arst_n low) empties the set at once; no clearing pass is run,
//   cells above the count are never compared as held.
`default_nettype none

module sorted_integer_set_unit (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         s_tvalid,
	output logic        s_tready,
	input  wire  [31:0] s_tdata,   // [31:0] key
	input  wire  [1:0]  s_tuser,   // [1:0] req_type
	output logic        m_tvalid,
	input  wire         m_tready,
	output logic [15:0] m_tdata    // [0] found, [6:1] position, [8:7] status, [15:9] count
);
	import sis_pkg::*;

	logic      s1_valid_q;
	req_t      req_s1;
	key_t      key_s1;
	cnt_t      count_q;
	cell_ctl_t ctl;
	logic      accept, advance, hit, full;
	idx_t      hit_idx;

	key_t                cell_key [CAPACITY];
	logic [CAPACITY-1:0] lt_vec, eq_vec;

	logic    found_nx;
	status_t status_nx;
	cnt_t    count_nx;

	logic        m_valid_q;
	logic [15:0] m_data_q;

	assign s_tready = !s1_valid_q;
	assign accept   = s_tvalid && s_tready;
	assign advance  = s1_valid_q && (!m_valid_q || m_tready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (accept) begin
			s1_valid_q <= 1'b1;
		end else if (advance) begin
			s1_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			req_s1 <= req_t'(s_tuser);
			key_s1 <= key_t'(s_tdata);
		end
	end

	assign hit  = |eq_vec;
	assign full = (count_q == cnt_t'(CAPACITY));

	always_comb begin
		hit_idx = '0;
		for (int i = 0; i < CAPACITY; i++) begin
			if (eq_vec[i]) begin
				hit_idx = hit_idx | idx_t'(i);
			end
		end
	end

	always_comb begin
		ctl         = '0;
		ctl.compare = accept;
		found_nx    = hit;
		count_nx    = count_q;
		case (req_s1)
			REQ_INSERT: begin
				if (hit) begin
					status_nx = STAT_DUP;
				end else if (full) begin
					status_nx = STAT_FULL;
				end else begin
					status_nx  = STAT_OK;
					ctl.insert = advance;
					count_nx   = count_q + cnt_t'(1);
				end
			end
			REQ_DELETE: begin
				if (hit) begin
					status_nx  = STAT_OK;
					ctl.remove = advance;
					count_nx   = count_q - cnt_t'(1);
				end else begin
					status_nx = STAT_MISS;
				end
			end
			default: begin
				status_nx = hit ? STAT_OK : STAT_MISS;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (advance) begin
			count_q <= count_nx;
		end
	end

	genvar g;
	generate
		for (g = 0; g < CAPACITY; g++) begin : g_cell
			logic occ;
			logic l_lt;
			key_t l_key, r_key;

			assign occ = cnt_t'(g) < count_q;
			if (g == 0) begin : g_first
				assign l_lt  = 1'b1;
				assign l_key = key_s1;
			end else begin : g_mid
				assign l_lt  = lt_vec[g-1];
				assign l_key = cell_key[g-1];
			end
			if (g == CAPACITY - 1) begin : g_last
				assign r_key = cell_key[g];
			end else begin : g_inner
				assign r_key = cell_key[g+1];
			end

			sis_cell u_cell (
				.clk       (clk),
				.arst_n    (arst_n),
				.ctl       (ctl),
				.cmp_key   (key_t'(s_tdata)),
				.ins_key   (key_s1),
				.occupied  (occ),
				.left_lt   (l_lt),
				.left_key  (l_key),
				.right_key (r_key),
				.key_q     (cell_key[g]),
				.lt_q      (lt_vec[g]),
				.eq_q      (eq_vec[g])
			);
		end
	endgenerate

	// Hold the result until the transfer completes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (advance) begin
			m_valid_q <= 1'b1;
		end else if (m_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			m_data_q <= {CNT_OUT_W'(count_nx), status_nx,
				(found_nx ? POS_OUT_W'(hit_idx) : POS_OUT_W'(0)), found_nx};
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = m_data_q;

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= cnt_t'(CAPACITY))
		else $error("key count above capacity");

	a_no_dup: assert property (@(posedge clk) disable iff (!arst_n)
		s1_valid_q |-> $onehot0(eq_vec))
		else $error("key matched in more than one cell");

	a_insert_grows: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.insert |=> count_q == $past(count_q) + cnt_t'(1))
		else $error("count did not grow after insert");

	a_remove_shrinks: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.remove |=> count_q == $past(count_q) - cnt_t'(1))
		else $error("count did not shrink after delete");

	a_result_after_advance: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> m_tvalid && !s1_valid_q)
		else $error("staged request lost on its way to the output");

endmodule

`default_nettype wire
